/* rtl/core/sutk_pkg.sv */
package sutk_pkg;

  // Default sizes of the keyword buffer and the position counters.
  localparam int KEYWORD_CHARS_DEF = 8;
  localparam int POSITION_BITS_DEF = 16;
  localparam int KW_COUNT = 40;

  // Lexer phase codes.
  localparam logic [4:0] P_IDLE       = 5'd0;
  localparam logic [4:0] P_SLASH      = 5'd1;
  localparam logic [4:0] P_LINE       = 5'd2;
  localparam logic [4:0] P_BLOCK      = 5'd3;
  localparam logic [4:0] P_BLOCK_STAR = 5'd4;
  localparam logic [4:0] P_WORD       = 5'd5;
  localparam logic [4:0] P_INT        = 5'd6;
  localparam logic [4:0] P_NUM_DOT    = 5'd7;
  localparam logic [4:0] P_FRAC       = 5'd8;
  localparam logic [4:0] P_STR        = 5'd9;
  localparam logic [4:0] P_STR_ESC    = 5'd10;
  localparam logic [4:0] P_CHR_OPEN   = 5'd11;
  localparam logic [4:0] P_CHR_ESC    = 5'd12;
  localparam logic [4:0] P_CHR_CLOSE  = 5'd13;
  localparam logic [4:0] P_OP_FIRST   = 5'd14;
  localparam logic [4:0] P_LT         = 5'd18;
  localparam logic [4:0] P_LT2        = 5'd19;
  localparam logic [4:0] P_GT         = 5'd20;
  localparam logic [4:0] P_GT2        = 5'd21;
  localparam logic [4:0] P_OP_LAST    = 5'd26;

  // Record kinds.
  localparam logic [1:0] REC_TEXT  = 2'd0;
  localparam logic [1:0] REC_TOKEN = 2'd1;
  localparam logic [1:0] REC_ERROR = 2'd2;

  // Error codes.
  localparam logic [2:0] ERR_NONE       = 3'd0;
  localparam logic [2:0] ERR_OPEN_BLOCK = 3'd1;
  localparam logic [2:0] ERR_OPEN_STR   = 3'd2;
  localparam logic [2:0] ERR_OPEN_CHR   = 3'd3;
  localparam logic [2:0] ERR_UNEXPECTED = 3'd4;

  // Token kinds that the lexer names directly.
  localparam logic [6:0] K_INT      = 7'd0;
  localparam logic [6:0] K_FLOAT    = 7'd1;
  localparam logic [6:0] K_STRING   = 7'd2;
  localparam logic [6:0] K_CHAR     = 7'd3;
  localparam logic [6:0] K_IDENT    = 7'd4;
  localparam logic [6:0] K_PUNCT0   = 7'd5;
  localparam logic [6:0] K_DOT      = 7'd8;
  localparam logic [6:0] K_SLASH_EQ = 7'd19;
  localparam logic [6:0] K_SLASH    = 7'd29;
  localparam logic [6:0] K_TILDE    = 7'd45;
  localparam logic [6:0] K_KW_BASE  = 7'd48;
  localparam logic [6:0] K_EOF      = 7'd88;
  localparam logic [6:0] K_NONE     = 7'd127;

  // Characters with a special role.
  localparam logic [7:0] CH_US  = "_";
  localparam logic [7:0] CH_BSL = "\\";
  localparam logic [7:0] CH_DQ  = "\"";
  localparam logic [7:0] CH_SQ  = "'";
  localparam logic [7:0] CH_NL  = 8'h0a;

  // One result record, without its last flag.
  typedef struct packed {
    logic [1:0]  rkind;
    logic [6:0]  tkind;
    logic [7:0]  tbyte;
    logic [15:0] line;
    logic [15:0] column;
    logic [2:0]  err;
  } rec_t;

  // One row of the operator table.
  typedef struct packed {
    logic [7:0] dbl;
    logic [6:0] dbl_kind;
    logic [6:0] eq_kind;
    logic [6:0] single;
  } op_row_t;

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_word(input logic [7:0] c);
    return is_alpha(c) || is_digit(c) || c == CH_US;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == " " || (c >= 8'd9 && c <= 8'd13);
  endfunction

  // Escape decoding inside string and character literals.
  function automatic logic [7:0] decode(input logic [7:0] c);
    logic [7:0] d;
    d = c;
    if (c == "n") d = 8'd10;
    else if (c == "t") d = 8'd9;
    else if (c == "0") d = 8'd0;
    return d;
  endfunction

  // Single-character punctuation, K_NONE when the byte is none.
  function automatic logic [6:0] punct_kind(input logic [7:0] c);
    logic [6:0] k;
    case (c)
      ";": k = K_PUNCT0;
      ",": k = K_PUNCT0 + 7'd1;
      ":": k = K_PUNCT0 + 7'd2;
      ".": k = K_PUNCT0 + 7'd3;
      "(": k = K_PUNCT0 + 7'd4;
      ")": k = K_PUNCT0 + 7'd5;
      "{": k = K_PUNCT0 + 7'd6;
      "}": k = K_PUNCT0 + 7'd7;
      "[": k = K_PUNCT0 + 7'd8;
      "]": k = K_PUNCT0 + 7'd9;
      "~": k = K_TILDE;
      default: k = K_NONE;
    endcase
    return k;
  endfunction

  // Phase that an operator's first character opens, P_IDLE when none.
  function automatic logic [4:0] op_phase(input logic [7:0] c);
    logic [4:0] p;
    case (c)
      "+": p = P_OP_FIRST;
      "-": p = P_OP_FIRST + 5'd1;
      "&": p = P_OP_FIRST + 5'd2;
      "|": p = P_OP_FIRST + 5'd3;
      "<": p = P_LT;
      ">": p = P_GT;
      "*": p = P_OP_FIRST + 5'd8;
      "%": p = P_OP_FIRST + 5'd9;
      "=": p = P_OP_FIRST + 5'd10;
      "!": p = P_OP_FIRST + 5'd11;
      "^": p = P_OP_FIRST + 5'd12;
      default: p = P_IDLE;
    endcase
    return p;
  endfunction

  // Operator table, one row per operator phase.
  function automatic op_row_t op_row(input logic [3:0] idx);
    op_row_t r;
    case (idx)
      4'd0:  r = '{"+", 7'd31, 7'd16, 7'd26};
      4'd1:  r = '{"-", 7'd32, 7'd17, 7'd27};
      4'd2:  r = '{"&", 7'd39, 7'd21, 7'd42};
      4'd3:  r = '{"|", 7'd40, 7'd22, 7'd43};
      4'd4:  r = '{"<", 7'd0, 7'd37, 7'd35};
      4'd5:  r = '{8'd0, 7'd0, 7'd24, 7'd46};
      4'd6:  r = '{">", 7'd0, 7'd38, 7'd36};
      4'd7:  r = '{8'd0, 7'd0, 7'd25, 7'd47};
      4'd8:  r = '{8'd0, 7'd0, 7'd18, 7'd28};
      4'd9:  r = '{8'd0, 7'd0, 7'd20, 7'd30};
      4'd10: r = '{8'd0, 7'd0, 7'd33, 7'd15};
      4'd11: r = '{8'd0, 7'd0, 7'd34, 7'd41};
      4'd12: r = '{8'd0, 7'd0, 7'd23, 7'd44};
      default: r = '{8'd0, 7'd0, 7'd0, 7'd0};
    endcase
    return r;
  endfunction

  // Keyword words as string literals, last character in the lowest byte.
  function automatic logic [63:0] kw_str(input logic [5:0] i);
    logic [63:0] s;
    case (i)
      6'd0:  s = "ank";      6'd1:  s = "shevti";   6'd2:  s = "jar";
      6'd3:  s = "nahitar";  6'd4:  s = "anyatha";  6'd5:  s = "he";
      6'd6:  s = "te";       6'd7:  s = "ahe";      6'd8:  s = "maze";
      6'd9:  s = "sthir";    6'd10: s = "sarve";    6'd11: s = "lahan";
      6'd12: s = "maha";     6'd13: s = "uch";      6'd14: s = "akshar";
      6'd15: s = "bhagank";  6'd16: s = "purnank";  6'd17: s = "vidhan";
      6'd18: s = "nirank";   6'd19: s = "agyat";    6'd20: s = "jovar";
      6'd21: s = "pratyek";  6'd22: s = "paryay";   6'd23: s = "thamba";
      6'd24: s = "pudhe";    6'd25: s = "partav";   6'd26: s = "karya";
      6'd27: s = "leeh";     6'd28: s = "khare";    6'd29: s = "khote";
      6'd30: s = "ani";      6'd31: s = "va";       6'd32: s = "varg";
      6'd33: s = "rachna";   6'd34: s = "navin";    6'd35: s = "vishes";
      6'd36: s = "prakar";   6'd37: s = "prayatna"; 6'd38: s = "apvaad";
      6'd39: s = "ayat";
      default: s = '0;
    endcase
    return s;
  endfunction

  // Keyword word with its first character in the lowest byte, zero padded.
  function automatic logic [63:0] kw_rom(input logic [5:0] i);
    logic [63:0] s;
    logic [63:0] w;
    logic [3:0]  n;
    s = kw_str(i);
    w = '0;
    n = '0;
    for (int b = 7; b >= 0; b--) begin
      if (s[8*b +: 8] != 8'd0) begin
        w[8*n[2:0] +: 8] = s[8*b +: 8];
        n = n + 4'd1;
      end
    end
    return w;
  endfunction

endpackage

/* rtl/core/source_tokenizer_unit.sv */
// Streaming lexer for a small C-like language.
// Input channel s_*: one source byte per beat in s_tdata; a beat with s_tlast
// set marks the end of the source (its byte is ignored), flushes the pending
// token, emits the end token and starts a fresh source.
// Output channel m_*: one record per beat (text byte, token record or error
// record); m_tlast marks the final record caused by one input beat. Input
// beats that cause no record produce no output beat.
// A beat is captured in the input register, lexed combinationally once the
// result bank is free, and its records are registered in the bank, which
// presents them. Throughput: one input beat per cycle while each beat yields
// at most one record and m_tready is high; the single output register bank
// drains one record per cycle while m_tready is high.
// When the receiver stalls, the bank holds its records, one more input beat
// waits in the input register, and then s_tready drops.
// Reset (synchronous, rst high) empties both registers and returns the lexer
// to line 1, column 1, between tokens.
module source_tokenizer_unit #(
  parameter int KEYWORD_CHARS = sutk_pkg::KEYWORD_CHARS_DEF,
  parameter int POSITION_BITS = sutk_pkg::POSITION_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // char_byte[7:0]
  input  logic        s_tlast,   // is_end
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // record_kind[1:0], token_kind[8:2], text_byte[16:9],
                                 // line[32:17], column[48:33], error_code[51:49], zero
  output logic        m_tlast    // last
);
  import sutk_pkg::*;

  // Input register.
  logic       in_full;
  logic [7:0] in_char;
  logic       in_end;

  // Result bank for the records of one input beat.
  rec_t       bank [4];
  logic [2:0] bcnt;
  logic [1:0] ridx;

  rec_t       lex_recs [4];
  logic [2:0] lex_cnt;
  logic       bank_free;
  logic       step;
  rec_t       cur;

  assign m_tvalid  = bcnt != 3'd0;
  assign bank_free = (bcnt == 3'd0) || (m_tready && ({1'b0, ridx} == bcnt - 3'd1));
  assign step      = in_full && bank_free;
  assign s_tready  = !in_full || step;

  sutk_lexer #(
    .KEYWORD_CHARS(KEYWORD_CHARS),
    .POSITION_BITS(POSITION_BITS)
  ) u_lexer (
    .clk      (clk),
    .rst      (rst),
    .step     (step),
    .char_byte(in_char),
    .is_end   (in_end),
    .recs     (lex_recs),
    .rec_count(lex_cnt)
  );

  // Input register loads whenever it is empty or being drained.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (s_tready) begin
      in_full <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_char <= s_tdata;
      in_end  <= s_tlast;
    end
  end

  // Result bank control: refill on a processed beat, else step through records.
  always_ff @(posedge clk) begin
    if (rst) begin
      bcnt <= '0;
      ridx <= '0;
    end else if (step) begin
      bcnt <= lex_cnt;
      ridx <= '0;
    end else if (m_tvalid && m_tready) begin
      if ({1'b0, ridx} == bcnt - 3'd1) bcnt <= '0;
      else ridx <= ridx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      for (int i = 0; i < 4; i++) bank[i] <= lex_recs[i];
    end
  end

  // Output beat from the current bank entry.
  assign cur     = bank[ridx];
  assign m_tdata = {4'd0, cur.err, cur.column, cur.line, cur.tbyte, cur.tkind, cur.rkind};
  assign m_tlast = {1'b0, ridx} == bcnt - 3'd1;

  // One beat never yields more than four records.
  a_bank_count: assert property (@(posedge clk) disable iff (rst) bcnt <= 3'd4)
    else $error("result bank count out of range");

  // The read index stays inside the filled part of the bank.
  a_ridx_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ({1'b0, ridx} < bcnt))
    else $error("result read index beyond bank count");

  // An end-of-source beat always leaves the end token as its final record.
  a_end_token: assert property (@(posedge clk) disable iff (rst)
    step && in_end |=> bcnt != 3'd0 && bank[2'(bcnt - 3'd1)].tkind == K_EOF)
    else $error("end of source without end token");

  // A processed beat frees the input register unless a new beat arrives.
  a_in_drain: assert property (@(posedge clk) disable iff (rst)
    step && !s_tvalid |=> !in_full)
    else $error("input register not drained");

endmodule

/* rtl/core/sutk_kwmatch.sv */
module sutk_kwmatch #(
  parameter int KEYWORD_CHARS = sutk_pkg::KEYWORD_CHARS_DEF,
  parameter int WLW = $clog2(KEYWORD_CHARS + 2)
) (
  input  logic [KEYWORD_CHARS-1:0][7:0] kbuf,
  input  logic [WLW-1:0]                wlen,
  output logic [6:0]                    word_kind
);
  import sutk_pkg::*;

  localparam int KW = KEYWORD_CHARS * 8;

  // Compare the buffered word against every keyword at once.
  always_comb begin
    word_kind = K_IDENT;
    if (wlen <= WLW'(KEYWORD_CHARS)) begin
      for (int i = 0; i < KW_COUNT; i++) begin
        if (kbuf == KW'(kw_rom(6'(i)))) word_kind = K_KW_BASE + 7'(i);
      end
    end
  end

endmodule

/* rtl/core/sutk_lexer.sv */
module sutk_lexer #(
  parameter int KEYWORD_CHARS = sutk_pkg::KEYWORD_CHARS_DEF,
  parameter int POSITION_BITS = sutk_pkg::POSITION_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic [7:0]       char_byte,
  input  logic             is_end,
  output sutk_pkg::rec_t   recs [4],
  output logic [2:0]       rec_count
);
  import sutk_pkg::*;

  localparam int WLW  = $clog2(KEYWORD_CHARS + 2);
  localparam int IDXW = $clog2(KEYWORD_CHARS);
  localparam int PB   = POSITION_BITS;

  // Lexer state.
  logic [4:0]                    phase, phase_next;
  logic [PB-1:0]                 line_count, line_count_next;
  logic [PB-1:0]                 column_count, column_count_next;
  logic [PB-1:0]                 start_line, start_line_next;
  logic [PB-1:0]                 start_column, start_column_next;
  logic [KEYWORD_CHARS-1:0][7:0] kbuf, kbuf_next;
  logic [WLW-1:0]                wlen, wlen_next;

  logic [6:0]  word_kind;
  logic        redo;
  op_row_t     row;
  logic [6:0]  pk;
  logic [4:0]  opp;

  function automatic rec_t mk(input logic [1:0] rk, input logic [6:0] tk,
                              input logic [7:0] tb, input logic [PB-1:0] l,
                              input logic [PB-1:0] col, input logic [2:0] err);
    rec_t r;
    r.rkind  = rk;
    r.tkind  = tk;
    r.tbyte  = tb;
    r.line   = 16'(l);
    r.column = 16'(col);
    r.err    = err;
    return r;
  endfunction

  sutk_kwmatch #(
    .KEYWORD_CHARS(KEYWORD_CHARS),
    .WLW          (WLW)
  ) u_kwmatch (
    .kbuf     (kbuf),
    .wlen     (wlen),
    .word_kind(word_kind)
  );

  // One item: up to two passes of the phase logic, then the position update; an end beat instead flushes and restarts.
  always_comb begin
    phase_next        = phase;
    line_count_next   = line_count;
    column_count_next = column_count;
    start_line_next   = start_line;
    start_column_next = start_column;
    kbuf_next         = kbuf;
    wlen_next         = wlen;
    rec_count         = '0;
    for (int i = 0; i < 4; i++) recs[i] = '0;
    redo = 1'b0;
    row  = '0;
    pk   = K_NONE;
    opp  = P_IDLE;

    if (is_end) begin
      // Flush the pending token, then the end token.
      case (phase)
        P_SLASH: begin
          recs[rec_count[1:0]] = mk(REC_TOKEN, K_SLASH, 8'd0, start_line, start_column, ERR_NONE);
          rec_count = rec_count + 3'd1;
        end
        P_WORD: begin
          recs[rec_count[1:0]] = mk(REC_TOKEN, word_kind, 8'd0, start_line, start_column,
                                    ERR_NONE);
          rec_count = rec_count + 3'd1;
        end
        P_INT: begin
          recs[rec_count[1:0]] = mk(REC_TOKEN, K_INT, 8'd0, start_line, start_column, ERR_NONE);
          rec_count = rec_count + 3'd1;
        end
        P_NUM_DOT: begin
          recs[rec_count[1:0]] = mk(REC_TOKEN, K_INT, 8'd0, start_line, start_column, ERR_NONE);
          rec_count = rec_count + 3'd1;
          recs[rec_count[1:0]] = mk(REC_TOKEN, K_DOT, 8'd0, line_count, column_count, ERR_NONE);
          rec_count = rec_count + 3'd1;
          // The held dot is counted before the end token.
          if (column_count_next != {PB{1'b1}}) column_count_next = column_count_next + PB'(1);
        end
        P_FRAC: begin
          recs[rec_count[1:0]] = mk(REC_TOKEN, K_FLOAT, 8'd0, start_line, start_column,
                                    ERR_NONE);
          rec_count = rec_count + 3'd1;
        end
        P_BLOCK, P_BLOCK_STAR: begin
          recs[rec_count[1:0]] = mk(REC_ERROR, 7'd0, 8'd0, line_count, column_count,
                                    ERR_OPEN_BLOCK);
          rec_count = rec_count + 3'd1;
        end
        P_STR, P_STR_ESC: begin
          recs[rec_count[1:0]] = mk(REC_ERROR, 7'd0, 8'd0, start_line, start_column,
                                    ERR_OPEN_STR);
          rec_count = rec_count + 3'd1;
          recs[rec_count[1:0]] = mk(REC_TOKEN, K_STRING, 8'd0, start_line, start_column,
                                    ERR_NONE);
          rec_count = rec_count + 3'd1;
        end
        P_CHR_OPEN, P_CHR_ESC, P_CHR_CLOSE: begin
          recs[rec_count[1:0]] = mk(REC_ERROR, 7'd0, 8'd0, start_line, start_column,
                                    ERR_OPEN_CHR);
          rec_count = rec_count + 3'd1;
          recs[rec_count[1:0]] = mk(REC_TOKEN, K_CHAR, 8'd0, start_line, start_column,
                                    ERR_NONE);
          rec_count = rec_count + 3'd1;
        end
        default: begin
          if (phase >= P_OP_FIRST && phase <= P_OP_LAST) begin
            row = op_row(4'(phase - P_OP_FIRST));
            recs[rec_count[1:0]] = mk(REC_TOKEN, row.single, 8'd0, start_line, start_column,
                                      ERR_NONE);
            rec_count = rec_count + 3'd1;
          end
        end
      endcase
      recs[rec_count[1:0]] = mk(REC_TOKEN, K_EOF, 8'd0, line_count_next, column_count_next,
                                ERR_NONE);
      rec_count = rec_count + 3'd1;
      // A fresh source starts after the end token.
      phase_next        = P_IDLE;
      line_count_next   = PB'(1);
      column_count_next = PB'(1);
      start_line_next   = PB'(1);
      start_column_next = PB'(1);
      kbuf_next         = '0;
      wlen_next         = '0;
    end else begin
      // Resolve a held dot after a number.
      if (phase_next == P_NUM_DOT) begin
        if (is_digit(char_byte)) begin
          recs[rec_count[1:0]] = mk(REC_TEXT, 7'd0, ".", start_line_next, start_column_next,
                                    ERR_NONE);
          rec_count  = rec_count + 3'd1;
          phase_next = P_FRAC;
        end else begin
          recs[rec_count[1:0]] = mk(REC_TOKEN, K_INT, 8'd0, start_line_next,
                                    start_column_next, ERR_NONE);
          rec_count         = rec_count + 3'd1;
          start_line_next   = line_count_next;
          start_column_next = column_count_next;
          recs[rec_count[1:0]] = mk(REC_TOKEN, K_DOT, 8'd0, start_line_next,
                                    start_column_next, ERR_NONE);
          rec_count  = rec_count + 3'd1;
          phase_next = P_IDLE;
        end
        if (column_count_next != {PB{1'b1}}) column_count_next = column_count_next + PB'(1);
      end

      if (phase_next == P_INT && char_byte == ".") begin
        phase_next = P_NUM_DOT;
      end else begin
        redo = 1'b1;
        for (int p = 0; p < 2; p++) begin
          if (redo) begin
            redo = 1'b0;
            case (phase_next)
              P_IDLE: begin
                start_line_next   = line_count_next;
                start_column_next = column_count_next;
                pk  = punct_kind(char_byte);
                opp = op_phase(char_byte);
                if (is_space(char_byte)) begin
                  phase_next = P_IDLE;
                end else if (char_byte == "/") begin
                  phase_next = P_SLASH;
                end else if (is_alpha(char_byte) || char_byte == CH_US) begin
                  phase_next   = P_WORD;
                  kbuf_next    = '0;
                  kbuf_next[0] = char_byte;
                  wlen_next    = WLW'(1);
                  recs[rec_count[1:0]] = mk(REC_TEXT, 7'd0, char_byte, start_line_next,
                                            start_column_next, ERR_NONE);
                  rec_count = rec_count + 3'd1;
                end else if (is_digit(char_byte)) begin
                  phase_next = P_INT;
                  recs[rec_count[1:0]] = mk(REC_TEXT, 7'd0, char_byte, start_line_next,
                                            start_column_next, ERR_NONE);
                  rec_count = rec_count + 3'd1;
                end else if (char_byte == CH_DQ) begin
                  phase_next = P_STR;
                end else if (char_byte == CH_SQ) begin
                  phase_next = P_CHR_OPEN;
                end else if (pk != K_NONE) begin
                  recs[rec_count[1:0]] = mk(REC_TOKEN, pk, 8'd0, start_line_next,
                                            start_column_next, ERR_NONE);
                  rec_count = rec_count + 3'd1;
                end else if (opp != P_IDLE) begin
                  phase_next = opp;
                end else begin
                  recs[rec_count[1:0]] = mk(REC_ERROR, 7'd0, char_byte, line_count_next,
                                            column_count_next, ERR_UNEXPECTED);
                  rec_count = rec_count + 3'd1;
                end
              end
              P_SLASH: begin
                if (char_byte == "/") begin
                  phase_next = P_LINE;
                end else if (char_byte == "*") begin
                  phase_next = P_BLOCK;
                end else if (char_byte == "=") begin
                  recs[rec_count[1:0]] = mk(REC_TOKEN, K_SLASH_EQ, 8'd0, start_line_next,
                                            start_column_next, ERR_NONE);
                  rec_count  = rec_count + 3'd1;
                  phase_next = P_IDLE;
                end else begin
                  recs[rec_count[1:0]] = mk(REC_TOKEN, K_SLASH, 8'd0, start_line_next,
                                            start_column_next, ERR_NONE);
                  rec_count  = rec_count + 3'd1;
                  phase_next = P_IDLE;
                  redo       = 1'b1;
                end
              end
              P_LINE: begin
                if (char_byte == CH_NL) phase_next = P_IDLE;
              end
              P_BLOCK: begin
                if (char_byte == "*") phase_next = P_BLOCK_STAR;
              end
              P_BLOCK_STAR: begin
                if (char_byte == "/") phase_next = P_IDLE;
                else if (char_byte != "*") phase_next = P_BLOCK;
              end
              P_WORD: begin
                if (is_word(char_byte)) begin
                  if (wlen_next < WLW'(KEYWORD_CHARS)) kbuf_next[wlen_next[IDXW-1:0]] = char_byte;
                  if (wlen_next <= WLW'(KEYWORD_CHARS)) wlen_next = wlen_next + WLW'(1);
                  recs[rec_count[1:0]] = mk(REC_TEXT, 7'd0, char_byte, start_line_next,
                                            start_column_next, ERR_NONE);
                  rec_count = rec_count + 3'd1;
                end else begin
                  recs[rec_count[1:0]] = mk(REC_TOKEN, word_kind, 8'd0, start_line_next,
                                            start_column_next, ERR_NONE);
                  rec_count  = rec_count + 3'd1;
                  phase_next = P_IDLE;
                  redo       = 1'b1;
                end
              end
              P_INT, P_FRAC: begin
                if (is_digit(char_byte)) begin
                  recs[rec_count[1:0]] = mk(REC_TEXT, 7'd0, char_byte, start_line_next,
                                            start_column_next, ERR_NONE);
                  rec_count = rec_count + 3'd1;
                end else begin
                  recs[rec_count[1:0]] = mk(REC_TOKEN, (phase_next == P_INT) ? K_INT : K_FLOAT,
                                            8'd0, start_line_next, start_column_next, ERR_NONE);
                  rec_count  = rec_count + 3'd1;
                  phase_next = P_IDLE;
                  redo       = 1'b1;
                end
              end
              P_STR: begin
                if (char_byte == CH_DQ) begin
                  recs[rec_count[1:0]] = mk(REC_TOKEN, K_STRING, 8'd0, start_line_next,
                                            start_column_next, ERR_NONE);
                  rec_count  = rec_count + 3'd1;
                  phase_next = P_IDLE;
                end else if (char_byte == CH_BSL) begin
                  phase_next = P_STR_ESC;
                end else begin
                  recs[rec_count[1:0]] = mk(REC_TEXT, 7'd0, char_byte, start_line_next,
                                            start_column_next, ERR_NONE);
                  rec_count = rec_count + 3'd1;
                end
              end
              P_STR_ESC: begin
                recs[rec_count[1:0]] = mk(REC_TEXT, 7'd0, decode(char_byte), start_line_next,
                                          start_column_next, ERR_NONE);
                rec_count  = rec_count + 3'd1;
                phase_next = P_STR;
              end
              P_CHR_OPEN: begin
                if (char_byte == CH_BSL) begin
                  phase_next = P_CHR_ESC;
                end else begin
                  recs[rec_count[1:0]] = mk(REC_TEXT, 7'd0, char_byte, start_line_next,
                                            start_column_next, ERR_NONE);
                  rec_count  = rec_count + 3'd1;
                  phase_next = P_CHR_CLOSE;
                end
              end
              P_CHR_ESC: begin
                recs[rec_count[1:0]] = mk(REC_TEXT, 7'd0, decode(char_byte), start_line_next,
                                          start_column_next, ERR_NONE);
                rec_count  = rec_count + 3'd1;
                phase_next = P_CHR_CLOSE;
              end
              P_CHR_CLOSE: begin
                phase_next = P_IDLE;
                if (char_byte != CH_SQ) begin
                  // Missing closing quote: the byte there is lexed again.
                  recs[rec_count[1:0]] = mk(REC_ERROR, 7'd0, 8'd0, start_line_next,
                                            start_column_next, ERR_OPEN_CHR);
                  rec_count = rec_count + 3'd1;
                  redo      = 1'b1;
                end
                recs[rec_count[1:0]] = mk(REC_TOKEN, K_CHAR, 8'd0, start_line_next,
                                          start_column_next, ERR_NONE);
                rec_count = rec_count + 3'd1;
              end
              default: begin
                if (phase_next < P_OP_FIRST || phase_next > P_OP_LAST) begin
                  phase_next = P_IDLE;
                  redo       = 1'b1;
                end else begin
                  row = op_row(4'(phase_next - P_OP_FIRST));
                  if (row.dbl != 8'd0 && char_byte == row.dbl) begin
                    if (phase_next == P_LT) begin
                      phase_next = P_LT2;
                    end else if (phase_next == P_GT) begin
                      phase_next = P_GT2;
                    end else begin
                      recs[rec_count[1:0]] = mk(REC_TOKEN, row.dbl_kind, 8'd0, start_line_next,
                                                start_column_next, ERR_NONE);
                      rec_count  = rec_count + 3'd1;
                      phase_next = P_IDLE;
                    end
                  end else if (char_byte == "=") begin
                    recs[rec_count[1:0]] = mk(REC_TOKEN, row.eq_kind, 8'd0, start_line_next,
                                              start_column_next, ERR_NONE);
                    rec_count  = rec_count + 3'd1;
                    phase_next = P_IDLE;
                  end else begin
                    recs[rec_count[1:0]] = mk(REC_TOKEN, row.single, 8'd0, start_line_next,
                                              start_column_next, ERR_NONE);
                    rec_count  = rec_count + 3'd1;
                    phase_next = P_IDLE;
                    redo       = 1'b1;
                  end
                end
              end
            endcase
          end
        end
        // Position of the next byte; both counters saturate.
        if (char_byte == CH_NL) begin
          if (line_count_next != {PB{1'b1}}) line_count_next = line_count_next + PB'(1);
          column_count_next = PB'(1);
        end else if (column_count_next != {PB{1'b1}}) begin
          column_count_next = column_count_next + PB'(1);
        end
      end
    end
  end

  // State update on each processed beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= P_IDLE;
      line_count   <= PB'(1);
      column_count <= PB'(1);
      start_line   <= PB'(1);
      start_column <= PB'(1);
      kbuf         <= '0;
      wlen         <= '0;
    end else if (step) begin
      phase        <= phase_next;
      line_count   <= line_count_next;
      column_count <= column_count_next;
      start_line   <= start_line_next;
      start_column <= start_column_next;
      kbuf         <= kbuf_next;
      wlen         <= wlen_next;
    end
  end

endmodule
